@@ hdl/bfba_pkg.sv @@
// shared types, codes and reset table contents of the best-fit block allocator
// no dependencies; imported by the controller, the datapath and the top level

package bfba_pkg;

  // fixed field widths of the request and result transactions
  localparam int REQ_W     = 11;
  localparam int STATUS_W  = 2;
  localparam int START_W   = 10;
  localparam int LEFT_W    = 10;
  localparam int ENTRIES_W = 7;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ZERO    = 2'd3;

  // the table starts out with four ranges
  localparam int INIT_ENTRIES = 4;
  localparam int INIT_IDX_W   = 2;
  localparam logic [INIT_IDX_W-1:0] INIT_LAST_IDX = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT,
    S_MARK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load_req;
    logic scan_step;
    logic shift_init;
    logic shift_step;
    logic write_split;
    logic write_best;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic req_zero;
    logic scan_issued;
    logic eval_busy;
    logic found;
    logic left_nz;
    logic table_full;
    logic shift_done;
  } stat_t;

  function automatic logic [15:0] init_first(input logic [INIT_IDX_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      2'd0:    v = 16'd0;
      2'd1:    v = 16'd200;
      2'd2:    v = 16'd500;
      default: v = 16'd700;
    endcase
    return v;
  endfunction

  // last address of the first three ranges; the fourth ends at the top of memory
  function automatic logic [15:0] init_last(input logic [INIT_IDX_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      2'd0:    v = 16'd199;
      2'd1:    v = 16'd499;
      default: v = 16'd699;
    endcase
    return v;
  endfunction

  function automatic logic init_used(input logic [INIT_IDX_W-1:0] idx);
    logic v;
    case (idx)
      2'd0:    v = 1'b1;
      2'd2:    v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/bfba_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; holds the range table of the allocator

module bfba_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bfba_ctrl.sv @@
// controller state machine of the allocator: sequences init, scan, shift and writes
// depends on bfba_pkg for the state, command and status types

module bfba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_stall,
  input  bfba_pkg::stat_t stat,
  output bfba_pkg::cmd_t  cmd,
  output logic           in_stall,
  output logic           out_valid
);
  import bfba_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.req_zero) state_next = S_FINISH;
        else if (stat.scan_issued && !stat.eval_busy) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.found) state_next = S_FINISH;
        else if (stat.left_nz && stat.table_full) state_next = S_FINISH;
        else if (stat.left_nz) state_next = S_SHIFT;
        else state_next = S_MARK;
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_SPLIT;
      end
      S_SPLIT: begin
        state_next = S_MARK;
      end
      S_MARK: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
      end
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = !stat.req_zero && !stat.scan_issued;
      end
      S_DECIDE: begin
        cmd.shift_init = stat.found && stat.left_nz && !stat.table_full;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      S_SPLIT: begin
        cmd.write_split = 1'b1;
      end
      S_MARK: begin
        cmd.write_best = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/bfba_datapath.sv @@
// datapath of the allocator: range table ram, best-fit scan, shift and result registers
// depends on bfba_pkg and bfba_ram

module bfba_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MEMORY_WORDS  = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bfba_pkg::cmd_t                   cmd,
  input  logic [bfba_pkg::REQ_W-1:0]       request_size,
  output bfba_pkg::stat_t                  stat,
  output logic [bfba_pkg::STATUS_W-1:0]    status,
  output logic [bfba_pkg::START_W-1:0]     granted_start,
  output logic [bfba_pkg::LEFT_W-1:0]      leftover_size,
  output logic [bfba_pkg::ENTRIES_W-1:0]   entries_in_use
);
  import bfba_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = (AW + 1 > REQ_W) ? AW + 1 : REQ_W;
  localparam int EW = 2 * AW + 1;

  // request and table fill
  logic [SW-1:0]         req;
  logic                  req_zero;
  logic [CW-1:0]         count;
  logic [INIT_IDX_W-1:0] init_idx;

  // scan state
  logic [CW-1:0] scan_idx;
  logic          eval_valid;
  logic [IW-1:0] eval_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [SW-1:0] best_left;
  logic [AW-1:0] best_first;
  logic [AW-1:0] best_last;

  // shift state
  logic [IW-1:0] shift_idx;
  logic          pend_valid;
  logic [IW-1:0] pend_addr;
  logic          shift_more;

  // set once the remainder entry is written, so filling the last slot still reads as a grant
  logic          split_done;

  // ram ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;

  // entry evaluation
  logic [AW-1:0] e_first;
  logic [AW-1:0] e_last;
  logic          e_used;
  logic [SW-1:0] e_size;
  logic [SW-1:0] e_left;
  logic          e_fit;
  logic          take;

  logic [AW-1:0]       split_first;
  logic [AW-1:0]       trim_last;
  logic [AW-1:0]       init_last_addr;
  logic [STATUS_W-1:0] res_status;

  bfba_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e_first = rdata[AW-1:0];
  assign e_last  = rdata[2*AW-1:AW];
  assign e_used  = rdata[EW-1];
  assign e_size  = SW'(e_last) - SW'(e_first) + SW'(1);
  assign e_left  = e_size - req;
  assign e_fit   = !e_used && (e_last >= e_first) && (e_size >= req);
  assign take    = eval_valid && e_fit && (!found || (e_left < best_left));

  assign shift_more  = shift_idx > best_idx;
  assign split_first = AW'(SW'(best_first) + req);
  assign trim_last   = AW'(SW'(best_first) + req - SW'(1));

  assign init_last_addr = (init_idx == INIT_LAST_IDX) ? AW'(MEMORY_WORDS - 1)
                                                      : AW'(init_last(init_idx));

  assign raddr = cmd.shift_step ? shift_idx : scan_idx[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.init_step) begin
      we    = 1'b1;
      waddr = IW'(init_idx);
      wdata = {init_used(init_idx), init_last_addr, AW'(init_first(init_idx))};
    end else if (pend_valid) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (cmd.write_split) begin
      we    = 1'b1;
      waddr = best_idx + IW'(1);
      wdata = {1'b0, best_last, split_first};
    end else if (cmd.write_best) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = {1'b1, (best_left != '0) ? trim_last : best_last, best_first};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx   <= '0;
      count      <= CW'(INIT_ENTRIES);
      eval_valid <= 1'b0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      req_zero   <= 1'b0;
      scan_idx   <= '0;
      split_done <= 1'b0;
    end else begin
      if (cmd.init_step) init_idx <= init_idx + INIT_IDX_W'(1);
      if (cmd.write_split) count <= count + CW'(1);

      eval_valid <= cmd.scan_step;
      if (cmd.load_req) begin
        req_zero   <= (request_size == '0);
        scan_idx   <= '0;
        found      <= 1'b0;
        split_done <= 1'b0;
      end else begin
        if (cmd.scan_step) scan_idx <= scan_idx + CW'(1);
        if (take) found <= 1'b1;
        if (cmd.write_split) split_done <= 1'b1;
      end

      // each shift read lands one entry higher on the next cycle
      pend_valid <= cmd.shift_step && shift_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= SW'(request_size);
    if (cmd.scan_step) eval_idx <= scan_idx[IW-1:0];
    if (take) begin
      best_idx   <= eval_idx;
      best_left  <= e_left;
      best_first <= e_first;
      best_last  <= e_last;
    end
    if (cmd.shift_init) begin
      shift_idx <= IW'(count - CW'(1));
    end else if (cmd.shift_step && shift_more) begin
      shift_idx <= shift_idx - IW'(1);
      pend_addr <= shift_idx + IW'(1);
    end
  end

  always_comb begin
    if (req_zero) res_status = STAT_ZERO;
    else if (!found) res_status = STAT_NO_FIT;
    else if ((best_left != '0) && !split_done && (count == CW'(TABLE_ENTRIES)))
      res_status = STAT_FULL;
    else res_status = STAT_GRANTED;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      granted_start  <= (res_status == STAT_GRANTED) ? START_W'(best_first) : '0;
      leftover_size  <= (res_status == STAT_GRANTED) ? LEFT_W'(best_left) : '0;
      entries_in_use <= ENTRIES_W'(count);
    end
  end

  assign stat.init_last   = (init_idx == INIT_LAST_IDX);
  assign stat.req_zero    = req_zero;
  assign stat.scan_issued = (scan_idx == count);
  assign stat.eval_busy   = eval_valid;
  assign stat.found       = found;
  assign stat.left_nz     = (best_left != '0);
  assign stat.table_full  = (count == CW'(TABLE_ENTRIES));
  assign stat.shift_done  = !shift_more && !pend_valid;

endmodule

@@ hdl/best_fit_block_allocator.sv @@
// best-fit block allocator, top level: joins the controller and the datapath
// depends on bfba_pkg, bfba_ctrl, bfba_datapath (and through it bfba_ram)

// Each request takes one range from a table of free and used address ranges kept in
// address order: the free range leaving the smallest remainder wins, ties to the lowest
// address, and a nonzero remainder is split off as a new free entry right after it.
// One request at a time is worked on. After reset the block loads the initial four ranges
// into the table ram and stalls requests meanwhile. The scan reads the table one entry per
// ram read through its single read port; when a split is made the later entries are then
// shifted up one place, and the writes and the result follow. A zero-size request skips
// the scan. The next request is taken once the result is registered, even while that
// result is still stalled.

module best_fit_block_allocator #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MEMORY_WORDS  = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bfba_pkg::REQ_W-1:0]     request_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfba_pkg::STATUS_W-1:0]  status,
  output logic [bfba_pkg::START_W-1:0]   granted_start,
  output logic [bfba_pkg::LEFT_W-1:0]    leftover_size,
  output logic [bfba_pkg::ENTRIES_W-1:0] entries_in_use
);
  import bfba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall),
    .out_valid(out_valid)
  );

  bfba_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .request_size  (request_size),
    .stat          (stat),
    .status        (status),
    .granted_start (granted_start),
    .leftover_size (leftover_size),
    .entries_in_use(entries_in_use)
  );

endmodule

@@ sim/best_fit_block_allocator_tb.sv @@
// testbench of the best-fit block allocator: directed requests, then random ones
// depends on bfba_pkg and best_fit_block_allocator; keeps its own copy of the range table

module best_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfba_pkg::*;

  localparam int TABLE_ENTRIES   = 64;
  localparam int MEMORY_WORDS    = 1024;
  localparam int RANDOM_REQUESTS = 1040;
  localparam int HOLD_CYCLES     = 400;
  localparam int DIRECTED_ROWS   = 13;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [START_W-1:0]   start;
    logic [LEFT_W-1:0]    left;
    logic [ENTRIES_W-1:0] entries;
  } alloc_result_t;

  typedef struct packed {
    logic [REQ_W-1:0] size;
    logic             has_expect;
    alloc_result_t    res;
  } directed_row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     request_size = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [START_W-1:0]   granted_start;
  logic [LEFT_W-1:0]    leftover_size;
  logic [ENTRIES_W-1:0] entries_in_use;

  // shadow of the range table
  logic [START_W-1:0]   seg_first [TABLE_ENTRIES];
  logic [START_W-1:0]   seg_last  [TABLE_ENTRIES];
  logic                 seg_used  [TABLE_ENTRIES];
  logic [ENTRIES_W-1:0] seg_count;

  alloc_result_t awaited_allocs [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            mismatch_count = 0;
  bit            hold_request   = 1'b0;

  best_fit_block_allocator #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MEMORY_WORDS  (MEMORY_WORDS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .request_size   (request_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_start  (granted_start),
    .leftover_size  (leftover_size),
    .entries_in_use (entries_in_use)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic reset_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      seg_first[i] = '0;
      seg_last[i]  = '0;
      seg_used[i]  = 1'b0;
    end
    seg_first[0] = 10'd0;   seg_last[0] = 10'd199; seg_used[0] = 1'b1;
    seg_first[1] = 10'd200; seg_last[1] = 10'd499; seg_used[1] = 1'b0;
    seg_first[2] = 10'd500; seg_last[2] = 10'd699; seg_used[2] = 1'b1;
    seg_first[3] = 10'd700; seg_last[3] = START_W'(MEMORY_WORDS - 1);
    seg_used[3]  = 1'b0;
    seg_count    = 7'd4;
  endtask

  // picks the free range with the smallest remainder, updates the shadow table
  function automatic alloc_result_t best_fit_alloc(input logic [REQ_W-1:0] size);
    alloc_result_t r;
    int req;
    int span;
    int best;
    int best_left;
    int head;
    bit found;
    logic [START_W-1:0] old_last;
    req       = int'(size);
    best      = 0;
    best_left = 0;
    found     = 1'b0;
    r.status  = STAT_GRANTED;
    r.start   = '0;
    r.left    = '0;
    if (req == 0) begin
      r.status  = STAT_ZERO;
      r.entries = seg_count;
      return r;
    end
    for (int i = 0; i < int'(seg_count); i++) begin
      if (!seg_used[i] && seg_last[i] >= seg_first[i]) begin
        span = int'(seg_last[i]) - int'(seg_first[i]) + 1;
        if (span >= req && (!found || span - req < best_left)) begin
          found     = 1'b1;
          best      = i;
          best_left = span - req;
        end
      end
    end
    if (!found) begin
      r.status = STAT_NO_FIT;
    end else if (best_left != 0 && int'(seg_count) >= TABLE_ENTRIES) begin
      r.status = STAT_FULL;
    end else begin
      head           = int'(seg_first[best]);
      seg_used[best] = 1'b1;
      if (best_left != 0) begin
        old_last = seg_last[best];
        for (int i = int'(seg_count); i > best + 1; i--) begin
          seg_first[i] = seg_first[i-1];
          seg_last[i]  = seg_last[i-1];
          seg_used[i]  = seg_used[i-1];
        end
        seg_last[best]    = START_W'(head + req - 1);
        seg_first[best+1] = START_W'(head + req);
        seg_last[best+1]  = old_last;
        seg_used[best+1]  = 1'b0;
        seg_count         = seg_count + 7'd1;
      end
      r.start = START_W'(head);
      r.left  = LEFT_W'(best_left);
    end
    r.entries = seg_count;
    return r;
  endfunction

  // before the table fills, mostly tiny splits so it does fill; afterwards mostly
  // exact fits of the remaining free ranges and requests that are refused
  function automatic logic [REQ_W-1:0] pick_request_size();
    int free_spans [$];
    int sel;
    for (int i = 0; i < int'(seg_count); i++) begin
      if (!seg_used[i]) free_spans.push_back(int'(seg_last[i]) - int'(seg_first[i]) + 1);
    end
    sel = int'($urandom_range(99, 0));
    if (int'(seg_count) < TABLE_ENTRIES) begin
      if (sel < 5) return '0;
      if (sel < 10) return REQ_W'($urandom_range(2047, 200));
      if (sel < 15) return REQ_W'($urandom_range(8, 1));
      return REQ_W'($urandom_range(2, 1));
    end
    if (sel < 8) return '0;
    if (sel < 45 && free_spans.size() > 0)
      return REQ_W'(free_spans[$urandom_range(free_spans.size() - 1, 0)]);
    if (sel < 70) return REQ_W'($urandom_range(16, 1));
    return REQ_W'($urandom_range(2047, 0));
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = int'($urandom_range(99, 0));
    if (sel < 60) return 0;
    if (sel < 90) return int'($urandom_range(3, 1));
    return int'($urandom_range(40, 8));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] size, input logic has_expect,
                              input alloc_result_t typed_res, input int gap);
    alloc_result_t predicted;
    request_size <= size;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // the shadow table advances on every transaction, typed rows included
    predicted = best_fit_alloc(size);
    awaited_allocs.push_back(has_expect ? typed_res : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : request_driver
    int gap;
    directed_rows = '{
      '{11'd0,    1'b1, '{STAT_ZERO,   10'd0, 10'd0, 7'd4}},
      '{11'd2047, 1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd4}},
      '{11'd1024, 1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd4}},
      '{11'd325,  1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd4}},
      '{11'd200,  1'b0, '0},
      // only the upper range holds this, leaving two free ranges of equal size
      '{11'd224,  1'b0, '0},
      // tie between the two, lower address wins
      '{11'd3,    1'b0, '0},
      '{11'd101,  1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd7}},
      '{11'd1,    1'b0, '0},
      '{11'd0,    1'b1, '{STAT_ZERO,   10'd0, 10'd0, 7'd8}},
      '{11'd2,    1'b0, '0},
      '{11'd1023, 1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd9}},
      '{11'd1536, 1'b1, '{STAT_NO_FIT, 10'd0, 10'd0, 7'd9}}
    };
    reset_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].size, directed_rows[k].has_expect,
                   directed_rows[k].res, pick_gap());
    end
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      gap = pick_gap();
      if (k % 250 < 40) gap = 0;
      // keep offering while the result side is held off
      if (k == 300) hold_request = 1'b1;
      if (k >= 300 && k < 330) gap = 0;
      if (k == 600) begin
        in_valid <= 1'b0;
        while (awaited_allocs.size() != 0) @(posedge clk);
      end
      send_request(pick_request_size(), 1'b0, '0, gap);
    end
    in_valid <= 1'b0;
    while (awaited_allocs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : stall_driver
    int sel;
    int len;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      sel = int'($urandom_range(99, 0));
      if (sel < 50) len = 0;
      else if (sel < 90) len = int'($urandom_range(3, 1));
      else len = int'($urandom_range(40, 8));
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      sel = int'($urandom_range(99, 0));
      if (sel < 70) len = int'($urandom_range(3, 1));
      else if (sel < 95) len = int'($urandom_range(20, 4));
      else len = int'($urandom_range(250, 100));
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_allocs.size() == 0) begin
        $error("result transaction with none expected, status %0d", status);
        mismatch_count++;
      end else begin
        want = awaited_allocs.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (granted_start !== want.start) begin
          $error("granted_start: expected %0d, got %0d", want.start, granted_start);
          mismatch_count++;
        end
        if (leftover_size !== want.left) begin
          $error("leftover_size: expected %0d, got %0d", want.left, leftover_size);
          mismatch_count++;
        end
        if (entries_in_use !== want.entries) begin
          $error("entries_in_use: expected %0d, got %0d", want.entries, entries_in_use);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #9_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
